/* rtl/sdws_pkg.sv */
// Shared types, codes and reset values for the straight-drive wheel sync block.
// Used by the top level and its port checker; depends on nothing else.
package sdws_pkg;

  // Default encoder count width
  localparam int unsigned COUNT_WIDTH = 24;

  // Field widths fixed by the interface
  localparam int unsigned ACT_W    = 3;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned FLAG_W   = 3;
  localparam int unsigned SPEED_W  = 8;
  localparam int unsigned DIR_W    = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned REPLY_W  = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned TARGET_W = 23;
  localparam int unsigned KP_W     = 16;
  localparam int unsigned KI_W     = 24;
  localparam int unsigned PERIOD_W = 10;
  localparam int unsigned INTEG_W  = 48;

  // Actions
  localparam logic [ACT_W-1:0] ACT_START  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_SAMPLE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_EVENT  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_CANCEL = 3'd3;
  localparam logic [ACT_W-1:0] ACT_RESUME = 3'd4;

  // Event flag bit positions
  localparam int unsigned EVT_EMERGENCY = 0;
  localparam int unsigned EVT_OBSTACLE  = 1;
  localparam int unsigned EVT_CLEARED   = 2;

  // Motor direction codes
  localparam logic [DIR_W-1:0] DIR_FWD  = 2'd0;
  localparam logic [DIR_W-1:0] DIR_BWD  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_STOP = 2'd2;

  // Task status codes
  localparam logic [STATUS_W-1:0] ST_IDLE      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_RUNNING   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_PAUSED    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DONE      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CANCELLED = 3'd4;

  // Event reply codes
  localparam logic [REPLY_W-1:0] RPL_IGNORE = 2'd0;
  localparam logic [REPLY_W-1:0] RPL_CANCEL = 2'd1;
  localparam logic [REPLY_W-1:0] RPL_PAUSE  = 2'd2;
  localparam logic [REPLY_W-1:0] RPL_RESUME = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TARGET  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KP      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KI      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD  = 3'd7;

  // Configuration reset values
  localparam logic [SPEED_W-1:0]  RST_BASE   = 8'd150;
  localparam logic [SPEED_W-1:0]  RST_MIN    = 8'd85;
  localparam logic [KP_W-1:0]     RST_KP     = 16'd77;
  localparam logic [KI_W-1:0]     RST_KI     = 24'd1678;
  localparam logic [PERIOD_W-1:0] RST_PERIOD = 10'd20;

  // Top speed in Q8 (255 * 256)
  localparam logic [16:0] SPEED_TOP_Q8 = 17'd65280;
  localparam logic [SPEED_W-1:0] SPEED_TOP = 8'd255;

endpackage

/* rtl/straight_drive_wheel_sync_pi_top.sv */
// Straight-drive task with PI wheel synchronization, one shared multiplier.
// Depends on sdws_pkg for codes, widths and reset values.
//
// Usage: one request on the input channel (valid/ready) carries an action,
// the millisecond time, both encoder counts and event flags. Each request
// yields exactly one result request on the output channel (valid/ready):
// wheel speeds, direction, update flag, task status and event reply.
// Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i;
// the user must write them only while the block is idle; the block does not enforce it.
// Flow: start, event, cancel, resume, unknown actions and a sample that
// stops early go from the dispatch step or the checks to the output step; a
// sample that runs the full PI update is stepped by the sequencer through one
// 25 x 25 multiplier (wider for counts above 24 bits) for five products
// and the two clamps.
// One request is worked at a time: a new one is taken only after the last is done.
// The result sits in an output register; the next request is accepted while
// it waits, and a stalled receiver only holds the sequencer at its last step.
// Reset clears all task state and loads the configuration reset values.
module straight_drive_wheel_sync_pi_top #(
  parameter int unsigned COUNT_WIDTH = sdws_pkg::COUNT_WIDTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [sdws_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [sdws_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [sdws_pkg::ACT_W-1:0]          action_i,
  input  logic [sdws_pkg::TIME_W-1:0]         now_ms_i,
  input  logic signed [COUNT_WIDTH-1:0]       left_count_i,
  input  logic signed [COUNT_WIDTH-1:0]       right_count_i,
  input  logic [sdws_pkg::FLAG_W-1:0]         event_flags_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [sdws_pkg::SPEED_W-1:0]        left_speed_o,
  output logic [sdws_pkg::SPEED_W-1:0]        right_speed_o,
  output logic [sdws_pkg::DIR_W-1:0]          motor_dir_o,
  output logic                                drive_update_o,
  output logic [sdws_pkg::STATUS_W-1:0]       task_status_o,
  output logic [sdws_pkg::REPLY_W-1:0]        event_reply_o
);

  localparam int unsigned CW   = COUNT_WIDTH;
  localparam int unsigned IW   = sdws_pkg::INTEG_W;
  localparam int unsigned MA   = 25;                         // gain / dt operand
  localparam int unsigned MB   = (CW + 1 > 25) ? CW + 1 : 25; // count / integral operand
  localparam int unsigned PW   = MA + MB;                    // product width
  localparam int unsigned AW   = PW + 25;                    // accumulator width
  localparam int unsigned CMPW = (CW > sdws_pkg::TARGET_W) ? CW : sdws_pkg::TARGET_W;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_TIMEOUT, S_PERIOD, S_DONECHK,
    S_MUL_DTLO, S_MUL_DTHI, S_MUL_KP, S_INTEG, S_MUL_KILO,
    S_MUL_KIHI, S_ACC_KI, S_CORR, S_LEFT, S_RIGHT, S_FIN
  } state_e;

  state_e state_q;

  // configuration
  logic [sdws_pkg::TARGET_W-1:0] target_q;
  logic                          reverse_q;
  logic [sdws_pkg::SPEED_W-1:0]  base_q;
  logic [sdws_pkg::SPEED_W-1:0]  min_q;
  logic [sdws_pkg::KP_W-1:0]     kp_q;
  logic [sdws_pkg::KI_W-1:0]     ki_q;
  logic [sdws_pkg::TIME_W-1:0]   timeout_q;
  logic [sdws_pkg::PERIOD_W-1:0] period_q;

  // task state
  logic                          running_q, paused_q, finished_q, cancelled_q;
  logic [sdws_pkg::TIME_W-1:0]   start_q, last_q;
  logic signed [IW-1:0]          integ_q;

  // captured request
  logic [sdws_pkg::ACT_W-1:0]    act_q;
  logic [sdws_pkg::TIME_W-1:0]   now_q;
  logic signed [CW-1:0]          lcnt_q, rcnt_q;
  logic [sdws_pkg::FLAG_W-1:0]   flags_q;

  // datapath
  logic [sdws_pkg::TIME_W-1:0]   dt_q;
  logic signed [CW:0]            err_q;
  logic signed [PW-1:0]          prod_q;
  logic signed [AW-1:0]          acc_q, corr_q;

  // working result
  logic [sdws_pkg::SPEED_W-1:0]  res_left_q, res_right_q;
  logic [sdws_pkg::DIR_W-1:0]    res_dir_q;
  logic                          res_upd_q;
  logic [sdws_pkg::REPLY_W-1:0]  res_reply_q;

  // output register
  logic                          out_valid_q;
  logic [sdws_pkg::SPEED_W-1:0]  out_left_q, out_right_q;
  logic [sdws_pkg::DIR_W-1:0]    out_dir_q;
  logic                          out_upd_q;
  logic [sdws_pkg::STATUS_W-1:0] out_status_q;
  logic [sdws_pkg::REPLY_W-1:0]  out_reply_q;

  logic                          in_fire;
  logic [sdws_pkg::DIR_W-1:0]    run_dir;
  logic [sdws_pkg::STATUS_W-1:0] status_now;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign run_dir    = reverse_q ? sdws_pkg::DIR_BWD : sdws_pkg::DIR_FWD;

  // Status by priority: cancelled, finished, paused, running
  always_comb begin
    if (cancelled_q) begin
      status_now = sdws_pkg::ST_CANCELLED;
    end else if (finished_q) begin
      status_now = sdws_pkg::ST_DONE;
    end else if (paused_q) begin
      status_now = sdws_pkg::ST_PAUSED;
    end else if (running_q) begin
      status_now = sdws_pkg::ST_RUNNING;
    end else begin
      status_now = sdws_pkg::ST_IDLE;
    end
  end

  // Early checks of a sample
  logic [sdws_pkg::TIME_W-1:0] elapsed, dt_now;
  logic                        tmo_hit, period_short;
  assign elapsed      = now_q - start_q;
  assign tmo_hit      = (timeout_q != '0) && (elapsed > timeout_q);
  assign dt_now       = now_q - last_q;
  assign period_short = dt_now < {{(sdws_pkg::TIME_W-sdws_pkg::PERIOD_W){1'b0}}, period_q};

  // Completion: larger absolute count against the target
  logic [CW-1:0]       abs_l, abs_r, abs_max;
  logic [CMPW-1:0]     abs_max_w, target_w;
  logic                reached;
  logic signed [CW:0]  err_now;
  assign abs_l     = lcnt_q[CW-1] ? (~lcnt_q + 1'b1) : lcnt_q;
  assign abs_r     = rcnt_q[CW-1] ? (~rcnt_q + 1'b1) : rcnt_q;
  assign abs_max   = (abs_l > abs_r) ? abs_l : abs_r;
  assign abs_max_w = CMPW'(abs_max);
  assign target_w  = CMPW'(target_q);
  assign reached   = abs_max_w >= target_w;
  assign err_now   = {lcnt_q[CW-1], lcnt_q} - {rcnt_q[CW-1], rcnt_q};

  // Shared multiplier operand select
  logic signed [MA-1:0] mul_a;
  logic signed [MB-1:0] mul_b;
  logic signed [PW-1:0] prod_d;
  always_comb begin
    mul_a = '0;
    mul_b = MB'(err_q);
    case (state_q)
      S_MUL_DTLO: mul_a = $signed(MA'(dt_q[15:0]));
      S_MUL_DTHI: mul_a = $signed(MA'(dt_q[31:16]));
      S_MUL_KP:   mul_a = $signed(MA'(kp_q));
      S_MUL_KILO: begin
        mul_a = $signed(MA'(ki_q));
        mul_b = $signed(MB'(integ_q[23:0]));
      end
      S_MUL_KIHI: begin
        mul_a = $signed(MA'(ki_q));
        mul_b = MB'($signed(integ_q[IW-1:24]));
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end
  assign prod_d = PW'(mul_a) * PW'(mul_b);

  // Integral update with saturation
  logic signed [AW-1:0] imax_w, imin_w, ineg_max_w, isum, integ_w;
  logic signed [IW-1:0] integ_d;
  assign imax_w     = {{(AW-IW+1){1'b0}}, {(IW-1){1'b1}}};
  assign imin_w     = {{(AW-IW+1){1'b1}}, {(IW-1){1'b0}}};
  assign ineg_max_w = imin_w + AW'(1);
  assign integ_w    = AW'(integ_q);
  assign isum       = integ_w + acc_q;
  always_comb begin
    if (acc_q > imax_w) begin
      integ_d = IW'(imax_w);
    end else if (acc_q < ineg_max_w) begin
      integ_d = IW'(imin_w);
    end else if (isum > imax_w) begin
      integ_d = IW'(imax_w);
    end else if (isum < imin_w) begin
      integ_d = IW'(imin_w);
    end else begin
      integ_d = IW'(isum);
    end
  end

  // Wheel speed: base -/+ correction, clamped to [min, 255]
  logic signed [AW-1:0] base_w, min_w, top_w, wheel_v;
  logic [sdws_pkg::SPEED_W-1:0] wheel_speed;
  assign base_w  = $signed(AW'({base_q, 8'h00}));
  assign min_w   = $signed(AW'({min_q, 8'h00}));
  assign top_w   = $signed(AW'(sdws_pkg::SPEED_TOP_Q8));
  assign wheel_v = (state_q == S_LEFT) ? (base_w - corr_q) : (base_w + corr_q);
  always_comb begin
    if (wheel_v > top_w) begin
      wheel_speed = sdws_pkg::SPEED_TOP;
    end else if (wheel_v < min_w) begin
      wheel_speed = min_q;
    end else begin
      wheel_speed = wheel_v[15:8];
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q  <= '0;
      reverse_q <= 1'b0;
      base_q    <= sdws_pkg::RST_BASE;
      min_q     <= sdws_pkg::RST_MIN;
      kp_q      <= sdws_pkg::RST_KP;
      ki_q      <= sdws_pkg::RST_KI;
      timeout_q <= '0;
      period_q  <= sdws_pkg::RST_PERIOD;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sdws_pkg::REG_TARGET:  target_q  <= cfg_wdata_i[sdws_pkg::TARGET_W-1:0];
        sdws_pkg::REG_REVERSE: reverse_q <= cfg_wdata_i[0];
        sdws_pkg::REG_BASE:    base_q    <= cfg_wdata_i[sdws_pkg::SPEED_W-1:0];
        sdws_pkg::REG_MIN:     min_q     <= cfg_wdata_i[sdws_pkg::SPEED_W-1:0];
        sdws_pkg::REG_KP:      kp_q      <= cfg_wdata_i[sdws_pkg::KP_W-1:0];
        sdws_pkg::REG_KI:      ki_q      <= cfg_wdata_i[sdws_pkg::KI_W-1:0];
        sdws_pkg::REG_TIMEOUT: timeout_q <= cfg_wdata_i;
        sdws_pkg::REG_PERIOD:  period_q  <= cfg_wdata_i[sdws_pkg::PERIOD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Payload capture and datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (in_fire) begin
      act_q   <= action_i;
      now_q   <= now_ms_i;
      lcnt_q  <= left_count_i;
      rcnt_q  <= right_count_i;
      flags_q <= event_flags_i;
    end
    case (state_q)
      S_PERIOD:   dt_q   <= dt_now;
      S_DONECHK:  err_q  <= err_now;
      S_MUL_DTHI: acc_q  <= AW'(prod_q);
      S_MUL_KP:   acc_q  <= acc_q + (AW'(prod_q) <<< 16);
      S_INTEG:    corr_q <= AW'(prod_q);
      S_MUL_KIHI: acc_q  <= AW'(prod_q);
      S_ACC_KI:   acc_q  <= acc_q + (AW'(prod_q) <<< 24);
      S_CORR:     corr_q <= corr_q + (acc_q >>> 16);
      default: begin
      end
    endcase
  end

  // Sequencer, task state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      running_q    <= 1'b0;
      paused_q     <= 1'b0;
      finished_q   <= 1'b0;
      cancelled_q  <= 1'b0;
      start_q      <= '0;
      last_q       <= '0;
      integ_q      <= '0;
      res_left_q   <= '0;
      res_right_q  <= '0;
      res_dir_q    <= '0;
      res_upd_q    <= 1'b0;
      res_reply_q  <= '0;
      out_valid_q  <= 1'b0;
      out_left_q   <= '0;
      out_right_q  <= '0;
      out_dir_q    <= '0;
      out_upd_q    <= 1'b0;
      out_status_q <= '0;
      out_reply_q  <= '0;
    end else begin
      // drain the output register unless the last step reloads it
      if (out_valid_q && out_ready_i && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            res_left_q  <= '0;
            res_right_q <= '0;
            res_dir_q   <= '0;
            res_upd_q   <= 1'b0;
            res_reply_q <= sdws_pkg::RPL_IGNORE;
            state_q     <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          // only a sample on an active task goes on to the checks
          if (act_q == sdws_pkg::ACT_SAMPLE && running_q && !cancelled_q &&
              !finished_q && !paused_q) begin
            state_q <= S_TIMEOUT;
          end else begin
            state_q <= S_FIN;
          end
          case (act_q)
            sdws_pkg::ACT_START: begin
              running_q   <= 1'b1;
              paused_q    <= 1'b0;
              finished_q  <= 1'b0;
              cancelled_q <= 1'b0;
              start_q     <= now_q;
              last_q      <= now_q;
              integ_q     <= '0;
              res_left_q  <= min_q;
              res_right_q <= min_q;
              res_dir_q   <= run_dir;
              res_upd_q   <= 1'b1;
            end
            sdws_pkg::ACT_SAMPLE: begin
            end
            sdws_pkg::ACT_EVENT: begin
              if (flags_q[sdws_pkg::EVT_EMERGENCY]) begin
                cancelled_q <= 1'b1;
                finished_q  <= 1'b1;
                res_dir_q   <= sdws_pkg::DIR_STOP;
                res_upd_q   <= 1'b1;
                res_reply_q <= sdws_pkg::RPL_CANCEL;
              end else if (flags_q[sdws_pkg::EVT_OBSTACLE]) begin
                paused_q    <= 1'b1;
                res_dir_q   <= sdws_pkg::DIR_STOP;
                res_upd_q   <= 1'b1;
                res_reply_q <= sdws_pkg::RPL_PAUSE;
              end else if (flags_q[sdws_pkg::EVT_CLEARED] && paused_q) begin
                paused_q    <= 1'b0;
                last_q      <= now_q;
                res_reply_q <= sdws_pkg::RPL_RESUME;
              end
            end
            sdws_pkg::ACT_CANCEL: begin
              cancelled_q <= 1'b1;
              finished_q  <= 1'b1;
              res_dir_q   <= sdws_pkg::DIR_STOP;
              res_upd_q   <= 1'b1;
            end
            sdws_pkg::ACT_RESUME: begin
              if (paused_q && !cancelled_q && !finished_q) begin
                paused_q <= 1'b0;
                last_q   <= now_q;
              end
            end
            default: begin
            end
          endcase
        end
        S_TIMEOUT: begin
          if (tmo_hit) begin
            cancelled_q <= 1'b1;
            finished_q  <= 1'b1;
            res_dir_q   <= sdws_pkg::DIR_STOP;
            res_upd_q   <= 1'b1;
            state_q     <= S_FIN;
          end else begin
            state_q <= S_PERIOD;
          end
        end
        S_PERIOD: begin
          if (period_short) begin
            state_q <= S_FIN;
          end else begin
            last_q  <= now_q;
            state_q <= S_DONECHK;
          end
        end
        S_DONECHK: begin
          if (reached) begin
            finished_q <= 1'b1;
            res_dir_q  <= sdws_pkg::DIR_STOP;
            res_upd_q  <= 1'b1;
            state_q    <= S_FIN;
          end else begin
            state_q <= S_MUL_DTLO;
          end
        end
        S_MUL_DTLO: state_q <= S_MUL_DTHI;
        S_MUL_DTHI: state_q <= S_MUL_KP;
        S_MUL_KP:   state_q <= S_INTEG;
        S_INTEG: begin
          integ_q <= integ_d;
          state_q <= S_MUL_KILO;
        end
        S_MUL_KILO: state_q <= S_MUL_KIHI;
        S_MUL_KIHI: state_q <= S_ACC_KI;
        S_ACC_KI:   state_q <= S_CORR;
        S_CORR:     state_q <= S_LEFT;
        S_LEFT: begin
          res_left_q <= wheel_speed;
          state_q    <= S_RIGHT;
        end
        S_RIGHT: begin
          res_right_q <= wheel_speed;
          res_dir_q   <= run_dir;
          res_upd_q   <= 1'b1;
          state_q     <= S_FIN;
        end
        S_FIN: begin
          // hold until the output register is free
          if (!out_valid_q || out_ready_i) begin
            out_valid_q  <= 1'b1;
            out_left_q   <= res_left_q;
            out_right_q  <= res_right_q;
            out_dir_q    <= res_dir_q;
            out_upd_q    <= res_upd_q;
            out_status_q <= status_now;
            out_reply_q  <= res_reply_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign left_speed_o   = out_left_q;
  assign right_speed_o  = out_right_q;
  assign motor_dir_o    = out_dir_q;
  assign drive_update_o = out_upd_q;
  assign task_status_o  = out_status_q;
  assign event_reply_o  = out_reply_q;

endmodule

/* rtl/sdws_checker.sv */
// Port-level checks for the straight-drive wheel sync block, bound to its top.
// Depends on sdws_pkg for codes and on straight_drive_wheel_sync_pi_top ports.
module sdws_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [sdws_pkg::SPEED_W-1:0]    left_speed_o,
  input logic [sdws_pkg::SPEED_W-1:0]    right_speed_o,
  input logic [sdws_pkg::DIR_W-1:0]      motor_dir_o,
  input logic                            drive_update_o,
  input logic [sdws_pkg::STATUS_W-1:0]   task_status_o,
  input logic [sdws_pkg::REPLY_W-1:0]    event_reply_o
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(left_speed_o) &&
      $stable(right_speed_o) && $stable(motor_dir_o) && $stable(task_status_o))
    else $error("stalled result changed");

  // One request at a time: ready drops after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while busy");

  // Without a new command the speeds and direction read zero
  a_no_cmd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !drive_update_o |-> left_speed_o == '0 &&
      right_speed_o == '0 && motor_dir_o == sdws_pkg::DIR_FWD)
    else $error("stale command fields");

  // A stop command carries zero speeds
  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && drive_update_o && motor_dir_o == sdws_pkg::DIR_STOP |->
      left_speed_o == '0 && right_speed_o == '0)
    else $error("stop with nonzero speed");

  // An emergency reply stops the motors and cancels the task
  a_emergency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_reply_o == sdws_pkg::RPL_CANCEL |->
      drive_update_o && motor_dir_o == sdws_pkg::DIR_STOP &&
      task_status_o == sdws_pkg::ST_CANCELLED)
    else $error("emergency reply without stop and cancel");

endmodule

bind straight_drive_wheel_sync_pi_top sdws_checker u_sdws_checker (.*);
